### rtl/core/rcpa_pkg.sv
// shared types, packet constants and the check byte mapping of the rc packet assembler
package rcpa_pkg;

	// packet geometry
	localparam int PKT_LEN = 14;
	localparam logic [3:0] LAST_IDX = 4'd13;

	// packet kinds
	typedef enum logic {
		CMD_DATA = 1'b0,
		CMD_BIND = 1'b1
	} cmd_t;

	// register index as decoded from the byte address
	localparam logic REG_ADDRESS_WORD = 1'b0;
	localparam logic [31:0] ADDRESS_WORD_RST = 32'h73D3_3130;

	typedef logic [7:0] byte_t;

	// fixed packet bytes
	localparam byte_t DATA_HDR   = 8'hC0;
	localparam byte_t BIND_HDR   = 8'hD0;
	localparam byte_t DATA_FLAGS = 8'h02;
	localparam byte_t BIND_FLAGS = 8'h03;
	localparam byte_t TRAILER    = 8'h05;
	localparam byte_t FILL       = 8'h40;
	localparam byte_t CHK_XOR    = 8'h0a;

	// flag bits
	localparam byte_t FLAG_CCW = 8'h80;
	localparam byte_t FLAG_CW  = 8'h40;
	localparam byte_t FLAG_ALT = 8'h20;
	localparam byte_t FLAG_CAL = 8'h04;
	localparam byte_t FLAG_LED = 8'h80;

	// stick output range
	localparam byte_t DEST_LO = 8'h2f;
	localparam byte_t DEST_HI = 8'hcf;
	localparam int SPAN = 160;

	// check byte from the 8-bit sum, bits a (7) down to h (0)
	function automatic byte_t check_map(input byte_t s);
		logic a, b, c, d, g, h;
		logic oa, ob, oc, od;
		byte_t low;
		a = s[7];
		b = s[6];
		c = s[5];
		d = s[4];
		g = s[1];
		h = s[0];
		low = s ^ CHK_XOR;
		od = ~(d ^ h);
		oc = (~c & ~d & g) | (c & ~d & ~g) | (~c & g & ~h) | (c & ~g & ~h)
			| (c & d & g & h) | (~c & d & ~g & h);
		ob = (~b & ~c & ~d) | (b & c & g) | (~b & ~c & ~g) | (~b & ~d & ~g)
			| (~b & ~c & ~h) | (~b & ~g & ~h) | (b & c & d & h) | (b & d & g & h);
		oa = (a & ~b) | (a & ~c & ~d) | (a & ~c & ~g) | (a & ~d & ~g)
			| (a & ~c & ~h) | (a & ~g & ~h) | (~a & b & c & g)
			| (~a & b & c & d & h) | (~a & b & d & g & h);
		return {oa, ob, oc, od, low[3:0]};
	endfunction

endpackage

### rtl/core/rc_packet_assembler.sv
// rc packet assembler: request capture, stick scaling, packet build and byte serialiser
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  req     | in        | req_valid / req_stall | cmd, rx_id, four sticks, five switches
//  pkt     | out       | pkt_valid / pkt_stall | pkt_byte, last (high on byte 13)
//  apb     | in/out    | psel, penable, pready | address_word at byte address 0
//
//  one packet is fourteen words; the byte serialiser sends one word per cycle unless
//  pkt_stall is high, and the next packet starts only after the last word is taken
//  the first word is presented once a request has passed the capture, scale and build
//  stages in that order, each stage held while the next one is full
//  a new request is taken while the previous packet is still being sent
//  reset clears the valid flags and the byte counter and loads address_word with 0x73D33130
//  a stall on pkt holds the current word and backs up into req once every stage is full
module rc_packet_assembler #(
	parameter int CHAN_LIMIT = 10000
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               cmd,
	input  logic [31:0]        rx_id,
	input  logic signed [15:0] throttle,
	input  logic signed [15:0] rudder,
	input  logic signed [15:0] elevator,
	input  logic signed [15:0] aileron,
	input  logic signed [15:0] leds,
	input  logic signed [15:0] roll_ccw,
	input  logic signed [15:0] roll_cw,
	input  logic signed [15:0] alt_hold,
	input  logic signed [15:0] calibrate,
	// packet channel
	output logic               pkt_valid,
	input  logic               pkt_stall,
	output logic [7:0]         pkt_byte,
	output logic               last
);

	// reciprocal scaling: byte = (SPAN * u) / DIV with u = clamped stick + limit
	localparam longint unsigned LIM     = longint'(CHAN_LIMIT);
	localparam longint unsigned DIV     = 2 * LIM;
	localparam longint unsigned SPAN_L  = longint'(rcpa_pkg::SPAN);
	localparam int              NUM_W   = $clog2(SPAN_L * DIV + 1);
	localparam int              DIV_W   = $clog2(DIV);
	localparam int              SHIFT   = NUM_W + DIV_W;
	localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIV - 1) / DIV;
	localparam longint unsigned MUL_K   = SPAN_L * RECIP;
	localparam int              U_W     = $clog2(DIV + 1);
	localparam int              P_W     = SHIFT + 8;
	localparam logic signed [16:0] LIM_S = 17'(CHAN_LIMIT);

	// configuration register
	logic [31:0] addr_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= rcpa_pkg::ADDRESS_WORD_RST;
		end else if (cfg_wr && paddr[2] == rcpa_pkg::REG_ADDRESS_WORD) begin
			addr_q <= pwdata;
		end
	end

	always_comb begin
		unique case (paddr[2])
			rcpa_pkg::REG_ADDRESS_WORD: prdata = addr_q;
			default:                    prdata = '0;
		endcase
	end

	// pipeline control
	logic       valid_s1, valid_s2, valid_s3;
	logic [3:0] idx_q;
	logic       out_take, last_take, adv2, adv3, req_take;

	assign out_take  = valid_s3 && !pkt_stall;
	assign last_take = out_take && idx_q == rcpa_pkg::LAST_IDX;
	assign adv3      = valid_s2 && (!valid_s3 || last_take);
	assign adv2      = valid_s1 && (!valid_s2 || adv3);
	assign req_stall = valid_s1 && valid_s2 && !adv3;
	assign req_take  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= 1'b1;
			end else if (adv3) begin
				valid_s2 <= 1'b0;
			end
			if (adv3) begin
				valid_s3 <= 1'b1;
			end else if (last_take) begin
				valid_s3 <= 1'b0;
			end
			if (last_take) begin
				idx_q <= '0;
			end else if (out_take) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// stage 1: request capture
	logic               cmd_s1;
	logic [31:0]        rx_id_s1;
	logic signed [15:0] stick_s1 [4];
	logic signed [15:0] leds_s1, ccw_s1, cw_s1, alt_s1, cal_s1;

	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_s1      <= cmd;
			rx_id_s1    <= rx_id;
			stick_s1[0] <= throttle;
			stick_s1[1] <= rudder;
			stick_s1[2] <= elevator;
			stick_s1[3] <= aileron;
			leds_s1     <= leds;
			ccw_s1      <= roll_ccw;
			cw_s1       <= roll_cw;
			alt_s1      <= alt_hold;
			cal_s1      <= calibrate;
		end
	end

	// clamp, offset and multiply by the scaled reciprocal, one lane per stick
	logic [U_W-1:0] u_c [4];
	logic [P_W-1:0] prod_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic signed [16:0] v;
			logic signed [16:0] off;
			v   = 17'(stick_s1[i]);
			off = v + LIM_S;
			if (v < -LIM_S) begin
				u_c[i] = '0;
			end else if (v > LIM_S) begin
				u_c[i] = U_W'(DIV);
			end else begin
				u_c[i] = U_W'(off);
			end
			prod_c[i] = P_W'(P_W'(u_c[i]) * P_W'(MUL_K));
		end
	end

	// switch flags from the raw sign
	rcpa_pkg::byte_t flags_c, led_c;

	always_comb begin
		flags_c = rcpa_pkg::DATA_FLAGS;
		if (ccw_s1 > 16'sd0) flags_c = flags_c | rcpa_pkg::FLAG_CCW;
		if (cw_s1 > 16'sd0)  flags_c = flags_c | rcpa_pkg::FLAG_CW;
		if (alt_s1 > 16'sd0) flags_c = flags_c | rcpa_pkg::FLAG_ALT;
		if (cal_s1 > 16'sd0) flags_c = flags_c | rcpa_pkg::FLAG_CAL;
		led_c = (leds_s1 > 16'sd0) ? rcpa_pkg::FLAG_LED : '0;
	end

	// stage 2: products and flags
	logic            cmd_s2;
	logic [31:0]     rx_id_s2;
	logic [P_W-1:0]  prod_s2 [4];
	rcpa_pkg::byte_t flags_s2, led_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2   <= cmd_s1;
			rx_id_s2 <= rx_id_s1;
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= prod_c[i];
			end
			flags_s2 <= flags_c;
			led_s2   <= led_c;
		end
	end

	// packet build
	rcpa_pkg::byte_t pkt_c [rcpa_pkg::PKT_LEN];
	rcpa_pkg::byte_t sum_a, sum_b, sum_c, sum_all;

	always_comb begin
		for (int i = 0; i < rcpa_pkg::PKT_LEN; i++) begin
			pkt_c[i] = '0;
		end
		if (rcpa_pkg::cmd_t'(cmd_s2) == rcpa_pkg::CMD_BIND) begin
			pkt_c[0] = rcpa_pkg::BIND_HDR;
			for (int i = 0; i < 4; i++) begin
				pkt_c[1 + i] = addr_q[24 - 8 * i +: 8];
				pkt_c[5 + i] = rx_id_s2[24 - 8 * i +: 8];
			end
			pkt_c[9]  = rcpa_pkg::BIND_FLAGS;
			pkt_c[10] = '0;
		end else begin
			pkt_c[0] = rcpa_pkg::DATA_HDR;
			for (int i = 0; i < 4; i++) begin
				pkt_c[1 + i] = prod_s2[i][SHIFT +: 8] + rcpa_pkg::DEST_LO;
				pkt_c[5 + i] = rcpa_pkg::FILL;
			end
			pkt_c[9]  = flags_s2;
			pkt_c[10] = led_s2;
		end
		pkt_c[11] = rcpa_pkg::TRAILER;
		sum_a   = pkt_c[0] + pkt_c[1] + pkt_c[2] + pkt_c[3];
		sum_b   = pkt_c[4] + pkt_c[5] + pkt_c[6] + pkt_c[7];
		sum_c   = pkt_c[8] + pkt_c[9] + pkt_c[10] + pkt_c[11];
		sum_all = sum_a + sum_b + sum_c;
		pkt_c[12] = sum_all;
		pkt_c[13] = rcpa_pkg::check_map(sum_all);
	end

	// stage 3: packet register feeding the byte serialiser
	rcpa_pkg::byte_t pkt_s3 [rcpa_pkg::PKT_LEN];

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int i = 0; i < rcpa_pkg::PKT_LEN; i++) begin
				pkt_s3[i] <= pkt_c[i];
			end
		end
	end

	assign pkt_valid = valid_s3;
	assign pkt_byte  = pkt_s3[idx_q];
	assign last      = idx_q == rcpa_pkg::LAST_IDX;

	// checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> idx_q <= rcpa_pkg::LAST_IDX)
		else $error("byte counter past the last word");

	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall && last |=> idx_q == 4'd0)
		else $error("byte counter did not restart after the last word");

	a_check_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && idx_q == rcpa_pkg::LAST_IDX |->
			pkt_s3[13] == rcpa_pkg::check_map(pkt_s3[12]))
		else $error("check byte does not match the sum byte");

	a_req_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> valid_s1)
		else $error("accepted request not held in the capture stage");

endmodule

### bench/rc_packet_assembler_test.sv
// self-checking testbench of the rc packet assembler: request stimulus, packet prediction, byte checks
`timescale 1ns / 1ps

module rc_packet_assembler_test;

	// register addresses and run limits
	localparam logic [2:0]  ADDR_ADDRESS_WORD = 3'd0;
	localparam logic [2:0]  ADDR_SPARE        = 3'd4;
	localparam logic [31:0] ADDRESS_WORD_INIT = 32'h73D3_3130;
	localparam int          STICK_LIMIT       = 10000;
	localparam int          CYCLE_LIMIT       = 200000;
	localparam int          HOLD_OFF_CYCLES   = 150;
	localparam int          HOLD_OFF_AFTER    = 60;

	typedef logic [7:0] octet_t;

	typedef struct packed {
		rcpa_pkg::cmd_t kind;
		logic [31:0] rx_id;
		logic [15:0] throttle;
		logic [15:0] rudder;
		logic [15:0] elevator;
		logic [15:0] aileron;
		logic [15:0] leds;
		logic [15:0] roll_ccw;
		logic [15:0] roll_cw;
		logic [15:0] alt_hold;
		logic [15:0] calibrate;
	} request_t;

	typedef struct packed {
		octet_t value;
		logic   tail;
	} packet_word_t;

	// predicts each packet and checks the byte stream against it
	class packet_book;
		localparam int     PKT_BYTES = 14;
		localparam octet_t HDR_DATA  = 8'hC0;
		localparam octet_t HDR_BIND  = 8'hD0;
		localparam octet_t FLAGS_DATA = 8'h02;
		localparam octet_t FLAGS_BIND = 8'h03;
		localparam octet_t TRAILER   = 8'h05;
		localparam octet_t FILLER    = 8'h40;
		localparam octet_t BIT_CCW   = 8'h80;
		localparam octet_t BIT_CW    = 8'h40;
		localparam octet_t BIT_ALT   = 8'h20;
		localparam octet_t BIT_CAL   = 8'h04;
		localparam octet_t BIT_LED   = 8'h80;
		localparam int     CODE_LO   = 8'h2f;
		localparam int     CODE_HI   = 8'hcf;

		packet_word_t pending_words[$];
		logic [31:0]  addr_word;
		int           mismatches;
		int           packets_noted;
		int           bind_noted;
		int           words_checked;

		function new();
			addr_word = ADDRESS_WORD_INIT;
			mismatches = 0;
			packets_noted = 0;
			bind_noted = 0;
			words_checked = 0;
		endfunction

		function void set_address(logic [31:0] w);
			addr_word = w;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		// clamp to the channel limit and map linearly onto the code range
		function octet_t stick_code(logic [15:0] raw);
			int v;
			v = $signed(raw);
			if (v < -STICK_LIMIT)
				v = -STICK_LIMIT;
			else if (v > STICK_LIMIT)
				v = STICK_LIMIT;
			return octet_t'(((CODE_HI - CODE_LO) * (v + STICK_LIMIT)) / (2 * STICK_LIMIT) + CODE_LO);
		endfunction

		function octet_t flag_when_positive(logic [15:0] raw, octet_t mask);
			return ($signed(raw) > 16'sd0) ? mask : 8'h00;
		endfunction

		// check byte: low nibble is the sum with two bits inverted, high nibble a fixed logic map
		function octet_t guard_byte(octet_t s);
			logic a, b, c, d, g, h;
			logic q4, q5, q6, q7;
			a = s[7];
			b = s[6];
			c = s[5];
			d = s[4];
			g = s[1];
			h = s[0];
			q4 = ~(d ^ h);
			q5 = (~c & ~d & g) | (c & ~d & ~g) | (~c & g & ~h) | (c & ~g & ~h)
				| (c & d & g & h) | (~c & d & ~g & h);
			q6 = (~b & ~c & ~d) | (b & c & g) | (~b & ~c & ~g) | (~b & ~d & ~g)
				| (~b & ~c & ~h) | (~b & ~g & ~h) | (b & c & d & h) | (b & d & g & h);
			q7 = (a & ~b) | (a & ~c & ~d) | (a & ~c & ~g) | (a & ~d & ~g)
				| (a & ~c & ~h) | (a & ~g & ~h) | (~a & b & c & g)
				| (~a & b & c & d & h) | (~a & b & d & g & h);
			return {q7, q6, q5, q4, s[3:0] ^ 4'ha};
		endfunction

		// build the fourteen bytes of one accepted request and queue them
		function void note_request(request_t r);
			octet_t pkt[PKT_BYTES];
			octet_t sum;
			int     k;
			for (k = 0; k < PKT_BYTES; k++)
				pkt[k] = 8'h00;
			if (r.kind == rcpa_pkg::CMD_BIND) begin
				pkt[0] = HDR_BIND;
				for (k = 0; k < 4; k++) begin
					pkt[1 + k] = addr_word[31 - 8 * k -: 8];
					pkt[5 + k] = r.rx_id[31 - 8 * k -: 8];
				end
				pkt[9] = FLAGS_BIND;
				bind_noted++;
			end else begin
				pkt[0] = HDR_DATA;
				pkt[1] = stick_code(r.throttle);
				pkt[2] = stick_code(r.rudder);
				pkt[3] = stick_code(r.elevator);
				pkt[4] = stick_code(r.aileron);
				for (k = 5; k <= 8; k++)
					pkt[k] = FILLER;
				pkt[9] = FLAGS_DATA | flag_when_positive(r.roll_ccw, BIT_CCW)
					| flag_when_positive(r.roll_cw, BIT_CW)
					| flag_when_positive(r.alt_hold, BIT_ALT)
					| flag_when_positive(r.calibrate, BIT_CAL);
				pkt[10] = flag_when_positive(r.leds, BIT_LED);
			end
			pkt[11] = TRAILER;
			sum = 8'h00;
			for (k = 0; k < 12; k++)
				sum = sum + pkt[k];
			pkt[12] = sum;
			pkt[13] = guard_byte(sum);
			for (k = 0; k < PKT_BYTES; k++)
				pending_words.push_back('{value: pkt[k], tail: (k == PKT_BYTES - 1)});
			packets_noted++;
		endfunction

		// compare one delivered word with the oldest outstanding one
		function void check_byte(octet_t got, logic got_last);
			packet_word_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual byte %02h last %0b",
					$time, got, got_last);
				mismatches++;
				return;
			end
			want = pending_words.pop_front();
			words_checked++;
			if (got !== want.value) begin
				$display("%0t: pkt_byte mismatch, expected %02h, actual %02h",
					$time, want.value, got);
				mismatches++;
			end
			if (got_last !== want.tail) begin
				$display("%0t: last mismatch, expected %0b, actual %0b",
					$time, want.tail, got_last);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid;
	logic               req_stall;
	logic               cmd;
	logic [31:0]        rx_id;
	logic signed [15:0] throttle;
	logic signed [15:0] rudder;
	logic signed [15:0] elevator;
	logic signed [15:0] aileron;
	logic signed [15:0] leds;
	logic signed [15:0] roll_ccw;
	logic signed [15:0] roll_cw;
	logic signed [15:0] alt_hold;
	logic signed [15:0] calibrate;
	logic               pkt_valid;
	logic               pkt_stall;
	logic [7:0]         pkt_byte;
	logic               last;

	packet_book book = new();
	int cycle_count = 0;
	int taken_count = 0;
	int burst_left = 0;
	int settings_used = 0;
	bit hold_done = 0;

	rc_packet_assembler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.rx_id     (rx_id),
		.throttle  (throttle),
		.rudder    (rudder),
		.elevator  (elevator),
		.aileron   (aileron),
		.leds      (leds),
		.roll_ccw  (roll_ccw),
		.roll_cw   (roll_cw),
		.alt_hold  (alt_hold),
		.calibrate (calibrate),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt_byte  (pkt_byte),
		.last      (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d words outstanding",
				cycle_count, book.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// packet word monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && pkt_valid === 1'b1 && pkt_stall === 1'b0)
			book.check_byte(pkt_byte, last);
	end

	// receiver: changing stall patterns plus one long hold-off
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		pkt_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && hold_left == 0 && taken_count >= HOLD_OFF_AFTER) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				pkt_stall = 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: pkt_stall = 1'b0;
					1: pkt_stall = ($urandom_range(0, 3) == 0);
					2: pkt_stall = ($urandom_range(0, 9) < 7);
					default: pkt_stall = mode_left[2];
				endcase
			end
		end
	end

	// configuration writes and reads
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (addr == ADDR_ADDRESS_WORD) begin
			book.set_address(data);
			settings_used++;
		end
	endtask

	task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want) begin
			$display("%0t: prdata mismatch, expected %08h, actual %08h", $time, want, prdata);
			book.mismatches++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// present one request and hold it until the block takes the request
	task automatic offer(input request_t r);
		@(negedge clk);
		cmd = r.kind;
		rx_id = r.rx_id;
		throttle = r.throttle;
		rudder = r.rudder;
		elevator = r.elevator;
		aileron = r.aileron;
		leds = r.leds;
		roll_ccw = r.roll_ccw;
		roll_cw = r.roll_cw;
		alt_hold = r.alt_hold;
		calibrate = r.calibrate;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		book.note_request(r);
		taken_count++;
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// sender works in bursts with random gaps between them
	task automatic send_bursty(input request_t r);
		if (burst_left == 0) begin
			pause_sender(($urandom_range(0, 5) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4));
			burst_left = $urandom_range(1, 10);
		end
		offer(r);
		burst_left--;
	endtask

	task automatic drain;
		@(negedge clk);
		req_valid = 1'b0;
		burst_left = 0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	function automatic request_t data_req(input int t, input int r, input int e, input int a,
			input int led, input int ccw, input int cw, input int alt, input int cal);
		request_t q;
		q.kind = rcpa_pkg::CMD_DATA;
		q.rx_id = $urandom();
		q.throttle = 16'(t);
		q.rudder = 16'(r);
		q.elevator = 16'(e);
		q.aileron = 16'(a);
		q.leds = 16'(led);
		q.roll_ccw = 16'(ccw);
		q.roll_cw = 16'(cw);
		q.alt_hold = 16'(alt);
		q.calibrate = 16'(cal);
		return q;
	endfunction

	function automatic request_t bind_req(input logic [31:0] id);
		request_t q;
		q = data_req(0, 0, 0, 0, 0, 0, 0, 0, 0);
		q.kind = rcpa_pkg::CMD_BIND;
		q.rx_id = id;
		return q;
	endfunction

	// sticks mostly near the useful range, sometimes anywhere in 16 bits
	function automatic logic [15:0] random_stick();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'(int'($urandom_range(0, 24000)) - 12000);
			2: return 16'(($urandom_range(0, 1) ? STICK_LIMIT : -STICK_LIMIT)
				+ int'($urandom_range(0, 2)) - 1);
			default: return 16'(int'($urandom_range(0, 2 * STICK_LIMIT)) - STICK_LIMIT);
		endcase
	endfunction

	function automatic logic [15:0] random_switch();
		return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom());
	endfunction

	function automatic request_t random_request();
		request_t q;
		q.kind = ($urandom_range(0, 9) < 3) ? rcpa_pkg::CMD_BIND : rcpa_pkg::CMD_DATA;
		q.rx_id = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom();
		q.throttle = random_stick();
		q.rudder = random_stick();
		q.elevator = random_stick();
		q.aileron = random_stick();
		q.leds = random_switch();
		q.roll_ccw = random_switch();
		q.roll_cw = random_switch();
		q.alt_hold = random_switch();
		q.calibrate = random_switch();
		return q;
	endfunction

	task automatic random_phase(input int count);
		repeat (count) send_bursty(random_request());
		drain();
	endtask

	// main sequence
	initial begin
		int k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		cmd = rcpa_pkg::CMD_DATA;
		rx_id = '0;
		throttle = '0;
		rudder = '0;
		elevator = '0;
		aileron = '0;
		leds = '0;
		roll_ccw = '0;
		roll_cw = '0;
		alt_hold = '0;
		calibrate = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of the address word
		apb_read_check(ADDR_ADDRESS_WORD, ADDRESS_WORD_INIT);
		settings_used++;

		// directed: field extremes, clamp edges, each switch alone, bind ids
		send_bursty(data_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_bursty(data_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_bursty(data_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_bursty(data_req(-10000, 10000, -10001, 10001, 1, 0, -1, 1, 0));
		send_bursty(data_req(-1, 1, 9999, -9999, 0, 1, 1, 1, 1));
		send_bursty(data_req(124, -124, 125, -125, -1, -1, -1, -1, -1));
		for (k = 0; k < 5; k++)
			send_bursty(data_req(5000, -5000, 2500, -2500, (k == 0) ? 1 : -1,
				(k == 1) ? 1 : -1, (k == 2) ? 1 : -1, (k == 3) ? 1 : -1, (k == 4) ? 1 : -1));
		send_bursty(bind_req(32'h0000_0000));
		send_bursty(bind_req(32'hFFFF_FFFF));
		send_bursty(bind_req(32'h1234_5678));
		send_bursty(bind_req(32'h8000_0001));
		drain();

		// all-ones address, a write to an unused index must leave it alone
		apb_write(ADDR_ADDRESS_WORD, 32'hFFFF_FFFF);
		apb_write(ADDR_SPARE, $urandom());
		apb_read_check(ADDR_ADDRESS_WORD, 32'hFFFF_FFFF);
		send_bursty(bind_req(32'h0000_0000));
		random_phase(50);

		// all-zero address
		apb_write(ADDR_ADDRESS_WORD, 32'h0000_0000);
		send_bursty(bind_req($urandom()));
		random_phase(50);

		// random address
		apb_write(ADDR_ADDRESS_WORD, $urandom());
		apb_read_check(ADDR_ADDRESS_WORD, book.addr_word);
		random_phase(50);

		// let any stray words show up
		repeat (30) @(posedge clk);
		$display("run covered %0d packets (%0d bind) and %0d words under %0d address settings",
			book.packets_noted, book.bind_noted, book.words_checked, settings_used);
		$display("output hold-off of %0d cycles applied: %0b", HOLD_OFF_CYCLES, hold_done);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/rcpa_pkg.sv
rtl/core/rc_packet_assembler.sv
bench/rc_packet_assembler_test.sv
